// ----- hw/rtl/m3inv_pkg.sv -----
// Shared widths, types, index tables and saturation helper for the 3x3 matrix inverse.
`default_nettype none
package m3inv_pkg;
	localparam int unsigned ELEM_W     = 32;
	localparam int unsigned THR_W      = 17;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned SHIFT_W    = 2 * FRAC_W;
	localparam int unsigned PROD_W     = 2 * ELEM_W;
	localparam int unsigned COF_W      = PROD_W + 1;
	localparam int unsigned CMAG_W     = PROD_W;
	localparam int unsigned TMAG_W     = CMAG_W + ELEM_W;
	localparam int unsigned DET_W      = TMAG_W + 3;
	localparam int unsigned MAG_W      = DET_W - 1;
	localparam int unsigned STEPS      = ELEM_W;
	localparam int unsigned REM_W      = MAG_W + STEPS;
	localparam int unsigned NELEM      = 9;
	localparam int unsigned NROW       = 3;
	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [ELEM_W-1:0] Q_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] Q_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
	localparam logic [THR_W-1:0]  THR_RESET = THR_W'(1);

	// Cofactor k is sign * (m[A]*m[D] - m[B]*m[C]), elements numbered row by row.
	localparam int unsigned COF_A [NELEM] = '{4, 3, 3, 1, 0, 0, 1, 0, 0};
	localparam int unsigned COF_D [NELEM] = '{8, 8, 7, 8, 8, 7, 5, 5, 4};
	localparam int unsigned COF_B [NELEM] = '{5, 5, 4, 2, 2, 1, 2, 2, 1};
	localparam int unsigned COF_C [NELEM] = '{7, 6, 6, 7, 6, 6, 4, 3, 3};
	localparam logic [NELEM-1:0] COF_NEG = 9'b010101010;

	// Output lane 3r+k takes the cofactor of row k, column r (transpose).
	localparam int unsigned LANE_SRC [NELEM] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

	typedef logic [NELEM-1:0][COF_W-1:0] cof_arr_t;

	typedef struct packed {
		cof_arr_t          cof;
		logic [MAG_W-1:0]  adet;
		logic              dneg;
		logic              sing;
		logic [ELEM_W-1:0] detv;
	} front_res_t;

	// Apply a sign to a magnitude and clamp into the Q16.16 range.
	function automatic logic [ELEM_W-1:0] sat_q(input logic [MAG_W-1:0] mag, input logic neg);
		logic [ELEM_W-1:0] r;
		if (neg) begin
			if (mag > MAG_W'(Q_MIN)) r = Q_MIN;
			else r = ELEM_W'(0) - mag[ELEM_W-1:0];
		end else begin
			if (mag > MAG_W'(Q_MAX)) r = Q_MAX;
			else r = mag[ELEM_W-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/m3inv_in_if.sv -----
// Input channel interface carrying one 3x3 matrix per transfer.
`default_nettype none
interface m3inv_in_if;
	import m3inv_pkg::*;
	logic valid;
	logic ready;
	logic signed [ELEM_W-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
	modport source(output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, input ready);
	modport sink(input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/m3inv_out_if.sv -----
// Output channel interface carrying one inverse, singular flag and determinant per transfer.
`default_nettype none
interface m3inv_out_if;
	import m3inv_pkg::*;
	logic valid;
	logic ready;
	logic signed [ELEM_W-1:0] inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33;
	logic singular;
	logic signed [ELEM_W-1:0] det_value;
	modport source(output valid, inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33,
		singular, det_value, input ready);
	modport sink(input valid, inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33,
		singular, det_value, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/m3inv_front.sv -----
// Front pipeline: cofactors, determinant, singular classification and rounded determinant.
`default_nettype none
module m3inv_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [m3inv_pkg::THR_W-1:0] thr,
	m3inv_in_if.sink                  in_ch,
	input  logic                      full,
	output logic                      push,
	output m3inv_pkg::front_res_t     res
);
	import m3inv_pkg::*;

	localparam int unsigned DEPTH = 8;

	logic [DEPTH-1:0] vld_q;
	logic             en;
	logic signed [ELEM_W-1:0] m [NELEM];

	logic signed [PROD_W-1:0] pa_s1 [NELEM];
	logic signed [PROD_W-1:0] pb_s1 [NELEM];
	logic signed [ELEM_W-1:0] row_s1 [NROW];
	cof_arr_t                 cof_s2;
	logic signed [ELEM_W-1:0] row_s2 [NROW];
	logic [CMAG_W-1:0]        cmag [NROW];
	logic [ELEM_W-1:0]        emag [NROW];
	logic [PROD_W-1:0]        pl_s3 [NROW];
	logic [PROD_W-1:0]        ph_s3 [NROW];
	logic [NROW-1:0]          sg_s3;
	cof_arr_t                 cof_s3;
	logic [TMAG_W-1:0]        mag_s4 [NROW];
	logic [NROW-1:0]          sg_s4;
	cof_arr_t                 cof_s4;
	logic signed [DET_W-1:0]  term_s5 [NROW];
	cof_arr_t                 cof_s5;
	logic signed [DET_W-1:0]  det_s6;
	cof_arr_t                 cof_s6;
	logic [MAG_W-1:0]         adet_s7;
	logic                     dneg_s7;
	cof_arr_t                 cof_s7;
	logic [MAG_W-1:0]         rdet;
	front_res_t               res_s8;

	assign m[0] = in_ch.m11;
	assign m[1] = in_ch.m12;
	assign m[2] = in_ch.m13;
	assign m[3] = in_ch.m21;
	assign m[4] = in_ch.m22;
	assign m[5] = in_ch.m23;
	assign m[6] = in_ch.m31;
	assign m[7] = in_ch.m32;
	assign m[8] = in_ch.m33;

	// The whole pipe moves unless its last stage holds an item the queue cannot take.
	assign en          = ~vld_q[DEPTH-1] | ~full;
	assign in_ch.ready = en;
	assign push        = vld_q[DEPTH-1] & ~full;
	assign res         = res_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_ch.valid};
		end
	end

	// Magnitudes of the first-row cofactors and elements for the determinant products.
	always_comb begin
		for (int j = 0; j < NROW; j++) begin
			cmag[j] = cof_s2[j][COF_W-1] ? CMAG_W'(COF_W'(0) - cof_s2[j]) : CMAG_W'(cof_s2[j]);
			emag[j] = row_s2[j][ELEM_W-1] ? ELEM_W'(0) - ELEM_W'(row_s2[j]) : ELEM_W'(row_s2[j]);
		end
	end

	// Rounded determinant magnitude in Q16.16.
	assign rdet = MAG_W'(adet_s7 >> SHIFT_W) + MAG_W'(adet_s7[SHIFT_W-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: the eighteen element products.
			for (int k = 0; k < NELEM; k++) begin
				pa_s1[k] <= PROD_W'(m[COF_A[k]]) * PROD_W'(m[COF_D[k]]);
				pb_s1[k] <= PROD_W'(m[COF_B[k]]) * PROD_W'(m[COF_C[k]]);
			end
			for (int j = 0; j < NROW; j++) row_s1[j] <= m[j];

			// Stage 2: signed cofactors.
			for (int k = 0; k < NELEM; k++) begin
				cof_s2[k] <= COF_NEG[k] ? COF_W'(pb_s1[k]) - COF_W'(pa_s1[k])
				                        : COF_W'(pa_s1[k]) - COF_W'(pb_s1[k]);
			end
			row_s2 <= row_s1;

			// Stage 3: half-width partial products of cofactor times element.
			for (int j = 0; j < NROW; j++) begin
				pl_s3[j] <= PROD_W'(cmag[j][ELEM_W-1:0]) * PROD_W'(emag[j]);
				ph_s3[j] <= PROD_W'(cmag[j][CMAG_W-1:ELEM_W]) * PROD_W'(emag[j]);
				sg_s3[j] <= cof_s2[j][COF_W-1] ^ row_s2[j][ELEM_W-1];
			end
			cof_s3 <= cof_s2;

			// Stage 4: join the partial products.
			for (int j = 0; j < NROW; j++) begin
				mag_s4[j] <= (TMAG_W'(ph_s3[j]) << ELEM_W) + TMAG_W'(pl_s3[j]);
			end
			sg_s4  <= sg_s3;
			cof_s4 <= cof_s3;

			// Stage 5: restore the sign of each term.
			for (int j = 0; j < NROW; j++) begin
				term_s5[j] <= sg_s4[j] ? DET_W'(0) - DET_W'(mag_s4[j]) : DET_W'(mag_s4[j]);
			end
			cof_s5 <= cof_s4;

			// Stage 6: exact determinant.
			det_s6 <= term_s5[0] + term_s5[1] + term_s5[2];
			cof_s6 <= cof_s5;

			// Stage 7: determinant magnitude and sign.
			adet_s7 <= det_s6[DET_W-1] ? MAG_W'(DET_W'(0) - det_s6) : MAG_W'(det_s6);
			dneg_s7 <= det_s6[DET_W-1];
			cof_s7  <= cof_s6;

			// Stage 8: classify against the threshold and round the determinant.
			res_s8.cof  <= cof_s7;
			res_s8.adet <= adet_s7;
			res_s8.dneg <= dneg_s7;
			res_s8.sing <= adet_s7 <= MAG_W'({thr, SHIFT_W'(0)});
			res_s8.detv <= sat_q(rdet, dneg_s7);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/m3inv_fifo.sv -----
// Short queue between the front and back pipelines.
`default_nettype none
module m3inv_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  m3inv_pkg::front_res_t wdata,
	input  logic                  pop,
	output m3inv_pkg::front_res_t rdata,
	output logic                  full,
	output logic                  avail
);
	import m3inv_pkg::*;

	front_res_t       mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = cnt_q == CNT_W'(FIFO_DEPTH);
	assign avail = cnt_q != CNT_W'(0);
	assign rdata = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/m3inv_back.sv -----
// Back pipeline: nine restoring dividers, one quotient bit per stage, rounding and output.
`default_nettype none
module m3inv_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  avail,
	input  m3inv_pkg::front_res_t res,
	output logic                  pop,
	m3inv_out_if.source           out_ch
);
	import m3inv_pkg::*;

	localparam int unsigned NSTG = STEPS + 3;

	logic [NSTG-1:0]    vld_q;
	logic               en;
	logic [COF_W-1:0]   csel [NELEM];
	logic [CMAG_W-1:0]  cmag [NELEM];
	logic [NELEM-1:0]   rb;

	logic [REM_W-1:0]   rem_s  [STEPS+1][NELEM];
	logic [ELEM_W-1:0]  q_s    [STEPS+1][NELEM];
	logic [NELEM-1:0]   neg_s  [STEPS+1];
	logic [NELEM-1:0]   ovf_s  [STEPS+1];
	logic [MAG_W-1:0]   adet_s [STEPS+1];
	logic               sing_s [STEPS+1];
	logic [ELEM_W-1:0]  detv_s [STEPS+1];

	logic [ELEM_W:0]    qr_s33 [NELEM];
	logic [NELEM-1:0]   neg_s33;
	logic [NELEM-1:0]   ovf_s33;
	logic               sing_s33;
	logic [ELEM_W-1:0]  detv_s33;

	logic [ELEM_W-1:0]  inv_s34 [NELEM];
	logic               sing_s34;
	logic [ELEM_W-1:0]  detv_s34;

	assign en  = ~vld_q[NSTG-1] | out_ch.ready;
	assign pop = avail & en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], avail};
		end
	end

	// Entry: pick the transposed cofactor for each lane and take its magnitude.
	always_comb begin
		for (int l = 0; l < NELEM; l++) begin
			csel[l] = res.cof[LANE_SRC[l]];
			cmag[l] = csel[l][COF_W-1] ? CMAG_W'(COF_W'(0) - csel[l]) : CMAG_W'(csel[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NELEM; l++) begin
				rem_s[0][l] <= REM_W'(cmag[l]) << SHIFT_W;
				q_s[0][l]   <= '0;
				neg_s[0][l] <= csel[l][COF_W-1] ^ res.dneg;
				ovf_s[0][l] <= MAG_W'(cmag[l]) >= res.adet;
			end
			adet_s[0] <= res.adet;
			sing_s[0] <= res.sing;
			detv_s[0] <= res.detv;
		end
	end

	// One restoring step per stage, most significant quotient bit first.
	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int unsigned SH = STEPS - 1 - j;
		logic [REM_W-1:0] dsh;
		logic [NELEM-1:0] ge;

		assign dsh = REM_W'(adet_s[j]) << SH;

		always_comb begin
			for (int l = 0; l < NELEM; l++) ge[l] = rem_s[j][l] >= dsh;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < NELEM; l++) begin
					rem_s[j+1][l] <= ge[l] ? rem_s[j][l] - dsh : rem_s[j][l];
					q_s[j+1][l]   <= {q_s[j][l][ELEM_W-2:0], ge[l]};
				end
				neg_s[j+1]  <= neg_s[j];
				ovf_s[j+1]  <= ovf_s[j];
				adet_s[j+1] <= adet_s[j];
				sing_s[j+1] <= sing_s[j];
				detv_s[j+1] <= detv_s[j];
			end
		end
	end

	// Round to nearest, ties away from zero: bump when twice the remainder reaches the divisor.
	always_comb begin
		for (int l = 0; l < NELEM; l++) begin
			rb[l] = (MAG_W+1)'({rem_s[STEPS][l][MAG_W-1:0], 1'b0}) >= (MAG_W+1)'(adet_s[STEPS]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NELEM; l++) begin
				qr_s33[l] <= (ELEM_W+1)'(q_s[STEPS][l]) + (ELEM_W+1)'(rb[l]);
			end
			neg_s33  <= neg_s[STEPS];
			ovf_s33  <= ovf_s[STEPS];
			sing_s33 <= sing_s[STEPS];
			detv_s33 <= detv_s[STEPS];
		end
	end

	// Output register: saturate, and force zero for a singular matrix.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NELEM; l++) begin
				if (sing_s33) inv_s34[l] <= '0;
				else if (ovf_s33[l]) inv_s34[l] <= neg_s33[l] ? Q_MIN : Q_MAX;
				else inv_s34[l] <= sat_q(MAG_W'(qr_s33[l]), neg_s33[l]);
			end
			sing_s34 <= sing_s33;
			detv_s34 <= detv_s33;
		end
	end

	assign out_ch.valid     = vld_q[NSTG-1];
	assign out_ch.inv11     = $signed(inv_s34[0]);
	assign out_ch.inv12     = $signed(inv_s34[1]);
	assign out_ch.inv13     = $signed(inv_s34[2]);
	assign out_ch.inv21     = $signed(inv_s34[3]);
	assign out_ch.inv22     = $signed(inv_s34[4]);
	assign out_ch.inv23     = $signed(inv_s34[5]);
	assign out_ch.inv31     = $signed(inv_s34[6]);
	assign out_ch.inv32     = $signed(inv_s34[7]);
	assign out_ch.inv33     = $signed(inv_s34[8]);
	assign out_ch.singular  = sing_s34;
	assign out_ch.det_value = $signed(detv_s34);
endmodule
`default_nettype wire

// ----- hw/rtl/matrix3_inverse_adjugate.sv -----
// Top level of the 3x3 matrix inverse by adjugate, Q16.16 in and out.
//
// Usage: matrix_in carries one 3x3 matrix (m11..m33, signed Q16.16) per
// transfer; inverse_out carries the inverse (inv11..inv33), the singular flag
// and the rounded determinant. Both use valid/ready; a transfer happens when
// both are high. cfg_we with cfg_wdata writes the singular threshold; write it
// only while no matrix is in flight.
// Pipeline: a matrix passes 8 front stages (the first loaded at the accepting edge),
// one queue entry, then 35 divider and output stages on its way to inverse_out.valid.
// Throughput: one matrix per cycle while nothing stalls; each of the 32 quotient bits of
// the nine divisions has its own stage, so a new matrix enters every cycle.
// Reset: arst_n clears all valid flags and the queue; the threshold returns to
// 1 (a determinant magnitude of 2^-16 or less counts as singular).
// Stall: when inverse_out.ready is low the back pipeline holds; the front
// keeps accepting into the two-entry queue, then drops matrix_in.ready until
// room frees up. No transfer is lost or repeated.
`default_nettype none
module matrix3_inverse_adjugate (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [m3inv_pkg::THR_W-1:0] cfg_wdata,
	m3inv_in_if.sink                    matrix_in,
	m3inv_out_if.source                 inverse_out
);
	import m3inv_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic             push;
	logic             pop;
	logic             full;
	logic             avail;
	front_res_t       f_res;
	front_res_t       q_res;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	m3inv_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.thr   (thr_q),
		.in_ch (matrix_in),
		.full  (full),
		.push  (push),
		.res   (f_res)
	);

	m3inv_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (f_res),
		.pop   (pop),
		.rdata (q_res),
		.full  (full),
		.avail (avail)
	);

	m3inv_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.avail (avail),
		.res   (q_res),
		.pop   (pop),
		.out_ch(inverse_out)
	);
endmodule
`default_nettype wire

// ----- hw/rtl/m3inv_checker.sv -----
// Port-level checker for the matrix inverse output channel, bound to the top level.
`default_nettype none
module m3inv_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               singular,
	input logic signed [31:0] det_value,
	input logic [31:0]        inv_or
);
	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its determinant.
	a_hold_det: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(det_value))
		else $error("determinant changed while stalled");

	// A singular matrix reports an all-zero inverse.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> inv_or == 32'd0)
		else $error("singular result with nonzero inverse");

	// A singular determinant lies within the largest threshold.
	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> (det_value <= 32'sd131072 && det_value >= -32'sd131072))
		else $error("singular result with large determinant");
endmodule

bind matrix3_inverse_adjugate m3inv_checker u_m3inv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(inverse_out.valid),
	.out_ready(inverse_out.ready),
	.singular (inverse_out.singular),
	.det_value(inverse_out.det_value),
	.inv_or   (inverse_out.inv11 | inverse_out.inv12 | inverse_out.inv13 |
	           inverse_out.inv21 | inverse_out.inv22 | inverse_out.inv23 |
	           inverse_out.inv31 | inverse_out.inv32 | inverse_out.inv33)
);
`default_nettype wire
